@@ rtl/core/rmi_pkg.sv @@
`default_nettype none

package rmi_pkg;

  // Operand width of residue and modulus
  localparam int unsigned MOD_BITS = 62;

  // Signed Bezout coefficient width, with headroom over the modulus
  localparam int unsigned COEF_W = MOD_BITS + 4;

  // Stream data widths, rounded up to whole bytes
  localparam int unsigned S_DATA_W = ((2 * MOD_BITS + 7) / 8) * 8;
  localparam int unsigned M_DATA_W = ((MOD_BITS + 7) / 8) * 8;

  typedef logic [MOD_BITS-1:0]       mod_t;
  typedef logic signed [COEF_W-1:0]  coef_t;

endpackage : rmi_pkg

`default_nettype wire

@@ rtl/core/residue_modular_inverse_top.sv @@
// An item answered at once (zero, unreduced, both operands even, or batch aborted) goes
//   from acceptance to ST_DONE and then to the output register; any other item first
//   runs the binary extended Euclid loop in ST_CALC, which takes one halve or subtract
//   step a cycle, and then the reduction in ST_FIX.
// Throughput: one request at a time; the next one is taken once the result is
//   handed to the output register, which may still wait on m_axis_tready_i.
// Reset: asynchronous, active low; clears the sequencer, output valid and abort flag.
`default_nettype none

module residue_modular_inverse_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Request stream
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata: residue [MOD_BITS-1:0], modulus [2*MOD_BITS-1:MOD_BITS], zero pad
  input  wire logic [rmi_pkg::S_DATA_W-1:0]   s_axis_tdata_i,
  // tlast: batch_end
  input  wire logic                           s_axis_tlast_i,
  // Result stream
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // tdata: inverse [MOD_BITS-1:0], zero pad
  output logic [rmi_pkg::M_DATA_W-1:0]        m_axis_tdata_o,
  // tuser: ok
  output logic                                m_axis_tuser_o,
  // tlast: batch_done
  output logic                                m_axis_tlast_o
);

  import rmi_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FIX,
    ST_DONE
  } state_e;

  state_e state_q;

  // Working registers of the Euclid loop: u = A*a + B*m, v = C*a + D*m
  mod_t  a_q, m_q, u_q, v_q;
  coef_t ca_q, cb_q, cc_q, cd_q;
  logic  res_ok_q, res_last_q, aborted_q;

  // Output register
  logic              m_valid_q, m_ok_q, m_last_q;
  mod_t              m_inv_q;

  // Request decode
  mod_t  in_res, in_mod;
  logic  in_last, in_accept, in_zero, in_reject;
  logic  out_free;

  assign in_res    = s_axis_tdata_i[MOD_BITS-1:0];
  assign in_mod    = s_axis_tdata_i[2*MOD_BITS-1:MOD_BITS];
  assign in_last   = s_axis_tlast_i;
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign in_zero   = (in_res == '0);
  // Answer at once: aborted batch, zero, unreduced, or both even (gcd >= 2)
  assign in_reject = aborted_q || in_zero || (in_res >= in_mod)
                     || (!in_res[0] && !in_mod[0]);
  assign out_free  = !m_valid_q || m_axis_tready_i;

  // Zero-extended operands for the coefficient updates
  coef_t a_ext, m_ext;
  assign a_ext = coef_t'({{(COEF_W-MOD_BITS){1'b0}}, a_q});
  assign m_ext = coef_t'({{(COEF_W-MOD_BITS){1'b0}}, m_q});

  // One loop step: halve an even value, else subtract the smaller from the larger
  mod_t  u_d, v_d;
  coef_t ca_d, cb_d, cc_d, cd_d;
  coef_t sum_x, sum_y;
  logic  u_ge_v;

  assign u_ge_v = (u_q >= v_q);

  always_comb begin
    u_d   = u_q;
    v_d   = v_q;
    ca_d  = ca_q;
    cb_d  = cb_q;
    cc_d  = cc_q;
    cd_d  = cd_q;
    sum_x = '0;
    sum_y = '0;
    if (!u_q[0]) begin
      u_d = u_q >> 1;
      if (!ca_q[0] && !cb_q[0]) begin
        sum_x = ca_q;
        sum_y = cb_q;
      end else begin
        sum_x = ca_q + m_ext;
        sum_y = cb_q - a_ext;
      end
      ca_d = sum_x >>> 1;
      cb_d = sum_y >>> 1;
    end else if (!v_q[0]) begin
      v_d = v_q >> 1;
      if (!cc_q[0] && !cd_q[0]) begin
        sum_x = cc_q;
        sum_y = cd_q;
      end else begin
        sum_x = cc_q + m_ext;
        sum_y = cd_q - a_ext;
      end
      cc_d = sum_x >>> 1;
      cd_d = sum_y >>> 1;
    end else if (u_ge_v) begin
      u_d  = u_q - v_q;
      ca_d = ca_q - cc_q;
      cb_d = cb_q - cd_q;
    end else begin
      v_d  = v_q - u_q;
      cc_d = cc_q - ca_q;
      cd_d = cd_q - cb_q;
    end
  end

  // Final reduction of C into [0, m)
  logic c_neg, c_big;
  assign c_neg = cc_q[COEF_W-1];
  assign c_big = !c_neg && (cc_q >= m_ext);

  // Sequencer, datapath and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      aborted_q  <= 1'b0;
      m_valid_q  <= 1'b0;
      res_ok_q   <= 1'b0;
      res_last_q <= 1'b0;
      m_ok_q     <= 1'b0;
      m_last_q   <= 1'b0;
    end else begin
      // Load a finished result, else drop the one taken
      if ((state_q == ST_DONE) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            a_q        <= in_res;
            m_q        <= in_mod;
            u_q        <= in_res;
            v_q        <= in_mod;
            ca_q       <= coef_t'(1);
            cb_q       <= '0;
            cc_q       <= '0;
            cd_q       <= coef_t'(1);
            res_last_q <= in_last;
            res_ok_q   <= 1'b0;
            aborted_q  <= (aborted_q || in_zero) && !in_last;
            state_q    <= in_reject ? ST_DONE : ST_CALC;
          end
        end
        ST_CALC: begin
          if (u_q == '0) begin
            res_ok_q <= (v_q == mod_t'(1));
            state_q  <= (v_q == mod_t'(1)) ? ST_FIX : ST_DONE;
          end else begin
            u_q  <= u_d;
            v_q  <= v_d;
            ca_q <= ca_d;
            cb_q <= cb_d;
            cc_q <= cc_d;
            cd_q <= cd_d;
          end
        end
        ST_FIX: begin
          if (c_neg) begin
            cc_q <= cc_q + m_ext;
          end else if (c_big) begin
            cc_q <= cc_q - m_ext;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_ok_q    <= res_ok_q;
            m_last_q  <= res_last_q;
            m_inv_q   <= res_ok_q ? cc_q[MOD_BITS-1:0] : '0;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(M_DATA_W-MOD_BITS){1'b0}}, m_inv_q};
  assign m_axis_tuser_o  = m_ok_q;
  assign m_axis_tlast_o  = m_last_q;

  // Loop never holds two even values, since both-even requests are rejected
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) |-> (u_q[0] || v_q[0]))
    else $error("euclid loop holds two even values");

  // A valid inverse modulo m >= 2 is never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_ok_q) |-> (m_inv_q != '0))
    else $error("valid result with zero inverse");

  // A failed result carries a zero inverse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_ok_q) |-> (m_inv_q == '0))
    else $error("failed result with nonzero inverse");

  // Abort persists until the batch end is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (aborted_q && !(in_accept && in_last)) |=> aborted_q)
    else $error("abort flag dropped inside a batch");

endmodule : residue_modular_inverse_top

`default_nettype wire

@@ test/residue_modular_inverse_top_tb.sv @@
`default_nettype none

module residue_modular_inverse_top_tb;
  import rmi_pkg::*;

  localparam logic [63:0] WORD_MASK = (64'd1 << MOD_BITS) - 64'd1;
  localparam logic [63:0] MERSENNE_61 = (64'd1 << 61) - 64'd1;
  localparam int unsigned MAX_IDLE = 7;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned DRAIN_CYCLES = 300;

  // Random batch content
  typedef enum int unsigned {
    KIND_INVERTIBLE,
    KIND_COMMON_FACTOR,
    KIND_UNREDUCED,
    KIND_ZERO,
    KIND_NOISE
  } item_kind_e;

  typedef struct packed {
    mod_t inverse;
    logic ok;
    logic batch_done;
  } inverse_result_t;

  // One directed request; known = 1 when the expected answer is typed in
  typedef struct packed {
    mod_t residue;
    mod_t modulus;
    logic last;
    logic known;
    mod_t inverse;
    logic ok;
  } directed_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic [S_DATA_W-1:0] s_data = '0;
  logic                s_last = 1'b0;
  logic                m_ready = 1'b0;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [M_DATA_W-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;
  logic                m_axis_tlast_o;

  inverse_result_t     expected_inverses[$];
  directed_row_t       directed_rows[$];
  logic                batch_aborted = 1'b0;
  int unsigned         mismatch_count = 0;
  int unsigned         req_max_idle = MAX_IDLE;
  int unsigned         resp_max_idle = MAX_IDLE;

  residue_modular_inverse_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // 20-unit clock period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Extended Euclid with wrapping 64-bit coefficients; 1 when gcd is one
  function automatic logic euclid_inverse(input logic [63:0] a, input logic [63:0] m,
                                          output logic [63:0] inv);
    logic [63:0] r_prev;
    logic [63:0] r_cur;
    logic [63:0] t_prev;
    logic [63:0] t_cur;
    logic [63:0] quot;
    logic [63:0] r_next;
    logic [63:0] t_next;
    r_prev = m;
    r_cur  = a;
    t_prev = 64'd0;
    t_cur  = 64'd1;
    inv    = 64'd0;
    while (r_cur != 64'd0) begin
      quot   = r_prev / r_cur;
      r_next = r_prev - quot * r_cur;
      t_next = t_prev - quot * t_cur;
      r_prev = r_cur;
      r_cur  = r_next;
      t_prev = t_cur;
      t_cur  = t_next;
    end
    if (r_prev != 64'd1) return 1'b0;
    // Fold a negative coefficient back into range
    if (t_prev[63]) t_prev = m + t_prev;
    inv = t_prev;
    return 1'b1;
  endfunction

  // Work out the answer to one request and advance the abort flag
  function automatic inverse_result_t predict_inverse(input mod_t residue, input mod_t modulus,
                                                      input logic last);
    inverse_result_t res;
    logic [63:0]     inv;
    res = '{inverse: '0, ok: 1'b0, batch_done: last};
    if (!batch_aborted) begin
      if (residue == '0) begin
        batch_aborted = 1'b1;
      end else if (residue < modulus) begin
        if (euclid_inverse({2'b00, residue}, {2'b00, modulus}, inv)) begin
          res.inverse = inv[MOD_BITS-1:0];
          res.ok      = 1'b1;
        end
      end
    end
    if (last) batch_aborted = 1'b0;
    return res;
  endfunction

  function automatic logic [63:0] rand_u64();
    return {$urandom, $urandom};
  endfunction

  // Random value of a random bit length, 0 to MOD_BITS
  function automatic mod_t rand_sized();
    int unsigned bits;
    logic [63:0] w;
    bits = $urandom_range(0, MOD_BITS);
    w    = rand_u64() & ((64'd1 << bits) - 64'd1);
    return w[MOD_BITS-1:0];
  endfunction

  task automatic add_row(input logic [63:0] residue, input logic [63:0] modulus,
                         input logic last, input logic known,
                         input logic [63:0] inverse, input logic ok);
    directed_rows.push_back('{residue: residue[MOD_BITS-1:0], modulus: modulus[MOD_BITS-1:0],
                              last: last, known: known, inverse: inverse[MOD_BITS-1:0],
                              ok: ok});
  endtask

  // Present one request after a random idle stretch; called and left at a falling edge
  task automatic send_request(input mod_t residue, input mod_t modulus, input logic last,
                              input logic known, input mod_t inverse, input logic ok);
    int unsigned     idle;
    inverse_result_t res;
    idle = $urandom_range(0, req_max_idle);
    if (idle != 0) begin
      s_valid <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {{(S_DATA_W - 2 * MOD_BITS){1'b0}}, modulus, residue};
    s_last  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    res = predict_inverse(residue, modulus, last);
    if (known) begin
      res.inverse = inverse;
      res.ok      = ok;
    end
    expected_inverses.push_back(res);
    @(negedge clk_i);
  endtask

  // Build one random request of the given kind
  task automatic make_request(input item_kind_e kind, output mod_t residue,
                              output mod_t modulus);
    int unsigned bits;
    logic [63:0] m;
    logic [63:0] r;
    logic [63:0] g;
    logic [63:0] q;
    bits = $urandom_range(2, MOD_BITS);
    m    = (rand_u64() & ((64'd1 << bits) - 64'd1)) | (64'd1 << (bits - 1));
    // Mostly odd moduli, so most reduced residues have an inverse
    if ($urandom_range(0, 3) != 0) m = m | 64'd1;
    r = 64'd0;
    case (kind)
      KIND_INVERTIBLE: begin
        r = rand_u64() % m;
        if (r == 64'd0) r = 64'd1;
      end
      KIND_COMMON_FACTOR: begin
        case ($urandom_range(0, 4))
          0:       g = 64'd2;
          1:       g = 64'd3;
          2:       g = 64'd6;
          3:       g = 64'd9;
          default: g = 64'd15;
        endcase
        q = m / g;
        if (q < 64'd2) q = 64'd2;
        m = q * g;
        r = g * (64'd1 + rand_u64() % (q - 64'd1));
      end
      KIND_UNREDUCED: begin
        r = m + rand_u64() % (WORD_MASK - m + 64'd1);
      end
      KIND_ZERO: begin
        r = 64'd0;
      end
      default: begin
        r = {2'b00, rand_sized()};
        m = {2'b00, rand_sized()};
      end
    endcase
    residue = r[MOD_BITS-1:0];
    modulus = m[MOD_BITS-1:0];
  endtask

  // Take results after random stalls and check them in order
  initial begin : result_side
    int unsigned     idle;
    inverse_result_t want;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      idle = $urandom_range(0, resp_max_idle);
      if (idle != 0) begin
        m_ready <= 1'b0;
        repeat (idle) @(negedge clk_i);
      end
      m_ready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      if (expected_inverses.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none outstanding: inverse %h ok %b done %b", $time,
                 m_axis_tdata_o[MOD_BITS-1:0], m_axis_tuser_o, m_axis_tlast_o);
      end else begin
        want = expected_inverses.pop_front();
        if (m_axis_tdata_o[MOD_BITS-1:0] !== want.inverse || m_axis_tuser_o !== want.ok ||
            m_axis_tlast_o !== want.batch_done) begin
          mismatch_count++;
          $display("%0t: expected inverse %h ok %b done %b, got inverse %h ok %b done %b",
                   $time, want.inverse, want.ok, want.batch_done,
                   m_axis_tdata_o[MOD_BITS-1:0], m_axis_tuser_o, m_axis_tlast_o);
        end
      end
      @(negedge clk_i);
    end
  end

  initial begin : request_side
    int unsigned   sent;
    int unsigned   batch_len;
    int unsigned   pick;
    item_kind_e    kind;
    mod_t          residue;
    mod_t          modulus;
    directed_row_t row;
    // residue, modulus, last, known, inverse, ok
    add_row(64'd1, 64'd2, 1'b0, 1'b1, 64'd1, 1'b1);
    add_row(64'd2, MERSENNE_61, 1'b0, 1'b1, 64'd1 << 60, 1'b1);
    add_row(MERSENNE_61 - 1, MERSENNE_61, 1'b0, 1'b1, MERSENNE_61 - 1, 1'b1);
    add_row(WORD_MASK - 1, WORD_MASK, 1'b0, 1'b1, WORD_MASK - 1, 1'b1);
    // residue equal to the modulus, then moduli zero and one
    add_row(WORD_MASK, WORD_MASK, 1'b0, 1'b1, 64'd0, 1'b0);
    add_row(64'd5, 64'd0, 1'b0, 1'b1, 64'd0, 1'b0);
    add_row(64'd1, 64'd1, 1'b1, 1'b1, 64'd0, 1'b0);
    // common factor, both even and of mixed parity, then a coprime odd pair
    add_row(64'd4, 64'd8, 1'b0, 1'b1, 64'd0, 1'b0);
    add_row(64'd6, 64'd9, 1'b0, 1'b1, 64'd0, 1'b0);
    add_row(64'd3, 64'd7, 1'b0, 1'b0, 64'd0, 1'b0);
    // zero residue aborts the rest of the batch
    add_row(64'd0, 64'd7, 1'b0, 1'b1, 64'd0, 1'b0);
    add_row(64'd3, 64'd7, 1'b0, 1'b1, 64'd0, 1'b0);
    add_row(WORD_MASK, 64'd5, 1'b1, 1'b1, 64'd0, 1'b0);
    add_row(64'd3, 64'd7, 1'b0, 1'b0, 64'd0, 1'b0);
    // zero residue on the marked item leaves the next batch clean
    add_row(64'd0, 64'd0, 1'b1, 1'b1, 64'd0, 1'b0);
    add_row(64'd3, 64'd7, 1'b0, 1'b0, 64'd0, 1'b0);
    add_row(64'd12345, MERSENNE_61, 1'b0, 1'b0, 64'd0, 1'b0);
    add_row(64'h2AAA_AAAA_AAAA_AAAA, WORD_MASK, 1'b0, 1'b0, 64'd0, 1'b0);
    add_row(64'h1555_5555_5555_5555, 64'h3555_5555_5555_5557, 1'b0, 1'b0, 64'd0, 1'b0);
    add_row(64'd1, WORD_MASK, 1'b1, 1'b1, 64'd1, 1'b1);
    add_row(64'd0, WORD_MASK, 1'b0, 1'b1, 64'd0, 1'b0);
    add_row(64'd1, 64'd3, 1'b0, 1'b1, 64'd0, 1'b0);
    add_row(64'd2, 64'd3, 1'b1, 1'b1, 64'd0, 1'b0);

    // Hold reset, then release it at a falling edge
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_request(row.residue, row.modulus, row.last, row.known, row.inverse, row.ok);
    end

    // Random batches; mostly well-formed content with some noise
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      req_max_idle  = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
      resp_max_idle = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
      batch_len     = $urandom_range(1, 8);
      for (int unsigned k = 0; k < batch_len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)      kind = KIND_INVERTIBLE;
        else if (pick < 78) kind = KIND_COMMON_FACTOR;
        else if (pick < 86) kind = KIND_UNREDUCED;
        else if (pick < 90) kind = KIND_ZERO;
        else                kind = KIND_NOISE;
        make_request(kind, residue, modulus);
        send_request(residue, modulus, k == batch_len - 1, 1'b0, '0, 1'b0);
        sent++;
      end
    end
    s_valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (expected_inverses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Abort a hung run
  initial begin : watchdog
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/core/rmi_pkg.sv
rtl/core/residue_modular_inverse_top.sv
test/residue_modular_inverse_top_tb.sv
